FILE: design/fia_pkg.sv
`timescale 1ns / 1ps

package fia_pkg;

  // Default table depth, entry zero included.
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  // Widths fixed by the register and payload fields.
  localparam int unsigned TOTAL_W = 11;
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic REG_BASE_INDEX    = 1'b0;
  localparam logic REG_TOTAL_ENTRIES = 1'b1;

  // Reset value of total_entries.
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_SET   = 2'd2,
    CMD_GET   = 2'd3
  } fia_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_NONE_FREE = 2'd2
  } fia_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_UNLINK,
    S_PUSH,
    S_PUSH_BACK,
    S_DONE
  } fia_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] flow_id;
    logic [63:0] obj_value;
  } fia_in_t;

  typedef struct packed {
    logic [31:0]        result_id;
    logic [63:0]        obj_out;
    logic [1:0]         status;
    logic [COUNT_W-1:0] used_count;
  } fia_out_t;

  // Strobes from the sequencer to the entry table.
  typedef struct packed {
    logic rd_en;
    logic next_we;
    logic prev_we;
    logic flag_we;
    logic hdl_we;
  } fia_tbl_ctl_t;

endpackage

FILE: design/fia_table.sv
`timescale 1ns / 1ps

module fia_table #(
  parameter int unsigned MAX_ENTRIES = fia_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  fia_pkg::fia_tbl_ctl_t      ctl,
  input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  input  logic [$clog2(MAX_ENTRIES)-1:0] next_waddr,
  input  logic [$clog2(MAX_ENTRIES)-1:0] next_wdata,
  input  logic [$clog2(MAX_ENTRIES)-1:0] prev_waddr,
  input  logic [$clog2(MAX_ENTRIES)-1:0] prev_wdata,
  input  logic [$clog2(MAX_ENTRIES)-1:0] flag_waddr,
  input  logic                       flag_wdata,
  input  logic [$clog2(MAX_ENTRIES)-1:0] hdl_waddr,
  input  logic [63:0]                hdl_wdata,
  output logic [$clog2(MAX_ENTRIES)-1:0] next_rdata,
  output logic [$clog2(MAX_ENTRIES)-1:0] prev_rdata,
  output logic                       flag_rdata,
  output logic [63:0]                hdl_rdata
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);

  logic [IW-1:0] next_mem [MAX_ENTRIES];
  logic [IW-1:0] prev_mem [MAX_ENTRIES];
  logic          flag_mem [MAX_ENTRIES];
  logic [63:0]   hdl_mem  [MAX_ENTRIES];

  // Each array has one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (ctl.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (ctl.flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (ctl.hdl_we) begin
      hdl_mem[hdl_waddr] <= hdl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      next_rdata <= next_mem[rd_addr];
      prev_rdata <= prev_mem[rd_addr];
      flag_rdata <= flag_mem[rd_addr];
      hdl_rdata  <= hdl_mem[rd_addr];
    end
  end

endmodule

FILE: design/fia_ctrl.sv
`timescale 1ns / 1ps

module fia_ctrl #(
  parameter int unsigned MAX_ENTRIES = fia_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rebuild,
  input  logic                       start,
  input  logic [1:0]                 start_cmd,
  input  logic [$clog2(MAX_ENTRIES)-1:0] start_idx,
  input  logic                       start_in_range,
  input  logic [63:0]                start_obj,
  input  logic [31:0]                base,
  input  logic [fia_pkg::TOTAL_W-1:0] eff_total,
  input  logic                       out_room,
  output logic                       busy,
  output logic                       done,
  output fia_pkg::fia_out_t          res,
  output fia_pkg::fia_tbl_ctl_t      tbl_ctl,
  output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  output logic [$clog2(MAX_ENTRIES)-1:0] next_waddr,
  output logic [$clog2(MAX_ENTRIES)-1:0] next_wdata,
  output logic [$clog2(MAX_ENTRIES)-1:0] prev_waddr,
  output logic [$clog2(MAX_ENTRIES)-1:0] prev_wdata,
  output logic [$clog2(MAX_ENTRIES)-1:0] flag_waddr,
  output logic                       flag_wdata,
  output logic [$clog2(MAX_ENTRIES)-1:0] hdl_waddr,
  output logic [63:0]                hdl_wdata,
  input  logic [$clog2(MAX_ENTRIES)-1:0] next_rdata,
  input  logic [$clog2(MAX_ENTRIES)-1:0] prev_rdata,
  input  logic                       flag_rdata,
  input  logic [63:0]                hdl_rdata
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

  fia_pkg::fia_state_t         state_r, state_nxt;
  fia_pkg::fia_cmd_t           cmd_r, cmd_nxt;
  logic [IW-1:0]               clr_r, clr_nxt;
  logic [IW-1:0]               head_r, head_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic                        ok_r, ok_nxt;
  logic [63:0]                 obj_r, obj_nxt;
  logic [fia_pkg::COUNT_W-1:0] count_r, count_nxt, count_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fia_pkg::S_CLEAR;
      clr_r   <= '0;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    ok_r  <= ok_nxt;
    obj_r <= obj_nxt;
  end

  // Count after the command completes, saturating both ways.
  always_comb begin
    count_upd = count_r;
    if (ok_r && cmd_r == fia_pkg::CMD_ALLOC && count_r != fia_pkg::COUNT_MAX) begin
      count_upd = count_r + 1'b1;
    end else if (ok_r && cmd_r == fia_pkg::CMD_FREE && count_r != '0) begin
      count_upd = count_r - 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    clr_nxt   = clr_r;
    head_nxt  = head_r;
    idx_nxt   = idx_r;
    ok_nxt    = ok_r;
    obj_nxt   = obj_r;
    count_nxt = count_r;

    tbl_ctl    = '0;
    rd_addr    = idx_r;
    next_waddr = '0;
    next_wdata = '0;
    prev_waddr = '0;
    prev_wdata = '0;
    flag_waddr = '0;
    flag_wdata = 1'b0;
    hdl_waddr  = '0;
    hdl_wdata  = '0;
    done       = 1'b0;
    busy       = (state_r != fia_pkg::S_IDLE);

    res.result_id  = (ok_r && cmd_r == fia_pkg::CMD_ALLOC) ? base + 32'(idx_r) : '0;
    res.obj_out    = (ok_r && cmd_r == fia_pkg::CMD_GET) ? hdl_rdata : '0;
    res.status     = ok_r ? fia_pkg::ST_DONE :
                     (cmd_r == fia_pkg::CMD_ALLOC) ? fia_pkg::ST_NONE_FREE :
                     fia_pkg::ST_IGNORED;
    res.used_count = count_upd;

    case (state_r)
      fia_pkg::S_CLEAR: begin
        // Rebuild the chain from entry zero upwards, one entry a cycle.
        tbl_ctl.next_we = 1'b1;
        tbl_ctl.prev_we = 1'b1;
        tbl_ctl.flag_we = 1'b1;
        tbl_ctl.hdl_we  = 1'b1;
        next_waddr = clr_r;
        next_wdata = (clr_r == '0) ? '0 : clr_r - 1'b1;
        prev_waddr = clr_r;
        prev_wdata = (32'(clr_r) + 32'd1 < 32'(eff_total)) ? clr_r + 1'b1 : '0;
        flag_waddr = clr_r;
        flag_wdata = (clr_r != '0) && (32'(clr_r) < 32'(eff_total));
        hdl_waddr  = clr_r;
        hdl_wdata  = '0;
        if (clr_r == LAST_IDX) begin
          head_nxt  = (eff_total > 11'd1) ? IW'(eff_total - 1'b1) : '0;
          state_nxt = fia_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      fia_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt = fia_pkg::fia_cmd_t'(start_cmd);
          obj_nxt = start_obj;
          case (fia_pkg::fia_cmd_t'(start_cmd))
            fia_pkg::CMD_ALLOC: begin
              idx_nxt = head_r;
              ok_nxt  = (head_r != '0);
            end
            fia_pkg::CMD_FREE: begin
              idx_nxt = start_idx;
              ok_nxt  = start_in_range && (start_idx != '0);
            end
            default: begin
              idx_nxt = start_idx;
              ok_nxt  = start_in_range;
            end
          endcase
          if (fia_pkg::fia_cmd_t'(start_cmd) == fia_pkg::CMD_ALLOC) begin
            state_nxt = (head_r != '0) ? fia_pkg::S_READ : fia_pkg::S_DONE;
          end else begin
            state_nxt = start_in_range ? fia_pkg::S_READ : fia_pkg::S_DONE;
          end
        end
      end
      fia_pkg::S_READ: begin
        if (!ok_r) begin
          // Free of entry zero lands here and is dropped.
          state_nxt = fia_pkg::S_DONE;
        end else begin
          tbl_ctl.rd_en = 1'b1;
          if (cmd_r == fia_pkg::CMD_SET) begin
            tbl_ctl.hdl_we = 1'b1;
            hdl_waddr      = idx_r;
            hdl_wdata      = obj_r;
          end
          if (cmd_r == fia_pkg::CMD_ALLOC || cmd_r == fia_pkg::CMD_FREE) begin
            state_nxt = fia_pkg::S_UNLINK;
          end else begin
            state_nxt = fia_pkg::S_DONE;
          end
        end
      end
      fia_pkg::S_UNLINK: begin
        if (flag_rdata) begin
          if (prev_rdata == '0) begin
            head_nxt = next_rdata;
          end else begin
            tbl_ctl.next_we = 1'b1;
            next_waddr      = prev_rdata;
            next_wdata      = next_rdata;
          end
          if (next_rdata != '0) begin
            tbl_ctl.prev_we = 1'b1;
            prev_waddr      = next_rdata;
            prev_wdata      = prev_rdata;
          end
          tbl_ctl.flag_we = 1'b1;
          flag_waddr      = idx_r;
          flag_wdata      = 1'b0;
        end
        if (cmd_r == fia_pkg::CMD_FREE) begin
          tbl_ctl.hdl_we = 1'b1;
          hdl_waddr      = idx_r;
          hdl_wdata      = '0;
          state_nxt      = fia_pkg::S_PUSH;
        end else begin
          state_nxt = fia_pkg::S_DONE;
        end
      end
      fia_pkg::S_PUSH: begin
        tbl_ctl.next_we = 1'b1;
        next_waddr      = idx_r;
        next_wdata      = head_r;
        tbl_ctl.flag_we = 1'b1;
        flag_waddr      = idx_r;
        flag_wdata      = 1'b1;
        if (head_r != '0) begin
          tbl_ctl.prev_we = 1'b1;
          prev_waddr      = head_r;
          prev_wdata      = idx_r;
        end
        state_nxt = fia_pkg::S_PUSH_BACK;
      end
      fia_pkg::S_PUSH_BACK: begin
        tbl_ctl.prev_we = 1'b1;
        prev_waddr      = idx_r;
        prev_wdata      = '0;
        head_nxt        = idx_r;
        state_nxt       = fia_pkg::S_DONE;
      end
      fia_pkg::S_DONE: begin
        if (out_room) begin
          done      = 1'b1;
          count_nxt = count_upd;
          state_nxt = fia_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fia_pkg::S_IDLE;
      end
    endcase

    if (rebuild) begin
      state_nxt = fia_pkg::S_CLEAR;
      clr_nxt   = '0;
      count_nxt = '0;
      head_nxt  = '0;
    end
  end

endmodule

FILE: design/flow_id_allocator.sv
`timescale 1ns / 1ps

// Flow identifier allocator with a doubly linked LIFO free list and one
// 64-bit object handle per entry. Each input transfer carries one command
// (alloc, free, set object, get object) and yields exactly one result
// transfer. The block handles one command at a time and raises in_stall
// while it works, so a new command is taken only once the last result is
// loaded into the output register. Set writes an entry's handle, get reads
// it; alloc reads the head entry and unlinks it; free reads the entry,
// unlinks it and pushes it back at the head. A command dropped for a bad id
// or an alloc with nothing free goes straight to its result, and a free of
// entry zero reads nothing and is dropped. The link arrays each have a
// single write port, so a free must read an entry's links, patch both
// neighbours, then patch the old head and the entry itself in two further
// steps. After reset, and after every write to either configuration
// register, a clearing pass rebuilds the list and zeroes the handles one
// entry per cycle, during which no input transfer is taken (configuration
// writes still are). The result waits in an output register, so a stall on
// the output side only holds the block once the next result is ready.
module flow_id_allocator #(
  parameter int unsigned MAX_ENTRIES = fia_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fia_pkg::fia_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fia_pkg::fia_out_t  out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);

  logic [31:0]                 base_r;
  logic [fia_pkg::TOTAL_W-1:0] total_r;
  logic [fia_pkg::TOTAL_W-1:0] eff_total;
  logic                        cfg_write;
  logic                        busy;
  logic                        start;
  logic [31:0]                 rel_id;
  logic                        in_range;
  logic                        done;
  fia_pkg::fia_out_t           res;
  logic                        out_valid_r, out_valid_nxt;
  fia_pkg::fia_out_t           out_data_r;
  logic                        out_room;

  fia_pkg::fia_tbl_ctl_t tbl_ctl;
  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [IW-1:0]         flag_waddr, hdl_waddr;
  logic                  flag_wdata;
  logic [63:0]           hdl_wdata;
  logic [IW-1:0]         next_rdata, prev_rdata;
  logic                  flag_rdata;
  logic [63:0]           hdl_rdata;

  // Configuration port. Any write, even one that does not change the value,
  // rebuilds the list.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      total_r <= fia_pkg::TOTAL_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == fia_pkg::REG_BASE_INDEX) begin
        base_r <= pwdata;
      end else begin
        total_r <= pwdata[fia_pkg::TOTAL_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fia_pkg::REG_TOTAL_ENTRIES) begin
      prdata = 32'(total_r);
    end else begin
      prdata = base_r;
    end
  end

  // A total beyond the table depth is clipped to the depth.
  assign eff_total = (32'(total_r) > 32'(MAX_ENTRIES)) ?
                     fia_pkg::TOTAL_W'(MAX_ENTRIES) : total_r;

  // Range test on the incoming id: the offset from the base, taken modulo
  // 2^32, must fall below the effective total, and id zero never matches.
  assign rel_id   = in_data.flow_id - base_r;
  assign in_range = (in_data.flow_id != '0) && (rel_id < 32'(eff_total));

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  fia_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .rebuild       (cfg_write),
    .start         (start),
    .start_cmd     (in_data.cmd),
    .start_idx     (rel_id[IW-1:0]),
    .start_in_range(in_range),
    .start_obj     (in_data.obj_value),
    .base          (base_r),
    .eff_total     (eff_total),
    .out_room      (out_room),
    .busy          (busy),
    .done          (done),
    .res           (res),
    .tbl_ctl       (tbl_ctl),
    .rd_addr       (rd_addr),
    .next_waddr    (next_waddr),
    .next_wdata    (next_wdata),
    .prev_waddr    (prev_waddr),
    .prev_wdata    (prev_wdata),
    .flag_waddr    (flag_waddr),
    .flag_wdata    (flag_wdata),
    .hdl_waddr     (hdl_waddr),
    .hdl_wdata     (hdl_wdata),
    .next_rdata    (next_rdata),
    .prev_rdata    (prev_rdata),
    .flag_rdata    (flag_rdata),
    .hdl_rdata     (hdl_rdata)
  );

  fia_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_table (
    .clk       (clk),
    .ctl       (tbl_ctl),
    .rd_addr   (rd_addr),
    .next_waddr(next_waddr),
    .next_wdata(next_wdata),
    .prev_waddr(prev_waddr),
    .prev_wdata(prev_wdata),
    .flag_waddr(flag_waddr),
    .flag_wdata(flag_wdata),
    .hdl_waddr (hdl_waddr),
    .hdl_wdata (hdl_wdata),
    .next_rdata(next_rdata),
    .prev_rdata(prev_rdata),
    .flag_rdata(flag_rdata),
    .hdl_rdata (hdl_rdata)
  );

  // Output register: it can take a new result when empty or when the
  // waiting result is transferred in the same cycle.
  assign out_room = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_ENTRIES = fia_pkg::MAX_ENTRIES_DEF;

  // The clock idles low and toggles every 10 ns, a period of 20 ns.
  logic clk = 1'b0;
  always #10 clk = ~clk;

  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  fia_pkg::fia_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  fia_pkg::fia_out_t out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  flow_id_allocator #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the allocator. It keeps its own copy of the registers, the doubly
  // linked free list, the handles and the count of entries in use, and is
  // advanced once for every input transfer, in the order of acceptance.
  // ---------------------------------------------------------------------------
  logic [31:0]                 base_q;
  logic [fia_pkg::TOTAL_W-1:0] total_q;
  logic [10:0]                 link_next [MAX_ENTRIES];
  logic [10:0]                 link_prev [MAX_ENTRIES];
  bit                          listed    [MAX_ENTRIES];
  logic [10:0]                 list_head;
  logic [63:0]                 handles   [MAX_ENTRIES];
  logic [fia_pkg::COUNT_W-1:0] used_q;

  // Results that the mirror expects, oldest first.
  fia_pkg::fia_out_t expected_results[$];

  int unsigned mismatch_count = 0;
  int          burst_left;
  bit          hold_req = 1'b0;

  // A total above the table depth is clamped to the depth.
  function automatic int unsigned live_entries();
    return (total_q > MAX_ENTRIES) ? MAX_ENTRIES : int'(total_q);
  endfunction

  // Rebuilds the list so that the highest entry sits at the head and clears
  // every handle, as reset and every register write do.
  function automatic void rebuild_list();
    int unsigned t;
    t = live_entries();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      link_next[i] = '0;
      link_prev[i] = '0;
      listed[i]    = 1'b0;
      handles[i]   = '0;
    end
    used_q    = '0;
    list_head = (t > 1) ? 11'(t - 1) : 11'd0;
    for (int unsigned i = 1; i < t; i++) begin
      link_next[i] = 11'(i - 1);
      link_prev[i] = (i + 1 < t) ? 11'(i + 1) : 11'd0;
      listed[i]    = 1'b1;
    end
  endfunction

  // Takes an entry out of the list wherever it sits; a no-op when it is not
  // on the list.
  function automatic void unlink_entry(int unsigned idx);
    logic [10:0] p;
    logic [10:0] n;
    if (!listed[idx]) return;
    p = link_prev[idx];
    n = link_next[idx];
    if (p == 0) list_head = n;
    else link_next[p] = n;
    if (n != 0) link_prev[n] = p;
    listed[idx] = 1'b0;
  endfunction

  function automatic fia_pkg::fia_out_t predict_result(fia_pkg::fia_in_t it);
    fia_pkg::fia_out_t r;
    logic [31:0]       idx;
    logic [10:0]       h;
    r        = '0;
    r.status = fia_pkg::ST_DONE;
    if (it.cmd == fia_pkg::CMD_ALLOC) begin
      h = list_head;
      if (h == 0) begin
        r.status = fia_pkg::ST_NONE_FREE;
      end else begin
        unlink_entry(h);
        r.result_id = base_q + 32'(h);
        if (used_q != fia_pkg::COUNT_MAX) used_q = used_q + 1'b1;
      end
    end else begin
      idx = it.flow_id - base_q;
      if (it.flow_id == 0 || idx >= live_entries()) begin
        r.status = fia_pkg::ST_IGNORED;
      end else if (it.cmd == fia_pkg::CMD_FREE) begin
        if (idx == 0) begin
          // Entry zero is reserved and never goes onto the list.
          r.status = fia_pkg::ST_IGNORED;
        end else begin
          handles[idx] = '0;
          unlink_entry(idx);
          // Push at the head; a double free simply moves the entry there.
          link_next[idx] = list_head;
          link_prev[idx] = '0;
          if (list_head != 0) link_prev[list_head] = 11'(idx);
          list_head   = 11'(idx);
          listed[idx] = 1'b1;
          if (used_q != 0) used_q = used_q - 1'b1;
        end
      end else if (it.cmd == fia_pkg::CMD_SET) begin
        handles[idx] = it.obj_value;
      end else begin
        r.obj_out = handles[idx];
      end
    end
    r.used_count = used_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed stimulus. Each row is either a register write or a command; a
  // command row carries a hand-written result only where it is obvious from
  // the state, otherwise the mirror supplies the expectation.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                is_cfg;
    logic              reg_sel;
    logic [31:0]       cfg_val;
    fia_pkg::fia_in_t  item;
    bit                typed;
    fia_pkg::fia_out_t want;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic void row_cfg(logic sel, logic [31:0] val);
    stim_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.cfg_val = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_cmd(fia_pkg::fia_cmd_t c, logic [31:0] id,
                                  logic [63:0] obj);
    stim_row_t row;
    row                = '{default: '0};
    row.item.cmd       = c;
    row.item.flow_id   = id;
    row.item.obj_value = obj;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_chk(fia_pkg::fia_cmd_t c, logic [31:0] id,
                                  logic [63:0] obj, logic [31:0] rid,
                                  logic [63:0] oout, fia_pkg::fia_status_t st,
                                  logic [fia_pkg::COUNT_W-1:0] cnt);
    stim_row_t row;
    row                = '{default: '0};
    row.item.cmd       = c;
    row.item.flow_id   = id;
    row.item.obj_value = obj;
    row.typed          = 1'b1;
    row.want.result_id  = rid;
    row.want.obj_out    = oout;
    row.want.status     = st;
    row.want.used_count = cnt;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Items go out in bursts of random length; between bursts valid
  // drops for a random gap. A gap is never empty, so valid never falls and
  // rises again within the same edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input fia_pkg::fia_in_t it, input bit typed,
                           input fia_pkg::fia_out_t want);
    int                gap;
    fia_pkg::fia_out_t pred;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    // in_stall is sampled as it stood just before the edge, which is the
    // value the block itself acts on.
    do @(posedge clk); while (in_stall);
    burst_left--;
    pred = predict_result(it);
    expected_results.push_back(typed ? want : pred);
  endtask

  // Stops offering items and waits until every expected transfer has come
  // back, then lets the pipeline settle before the registers are touched.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A write takes a setup and an access cycle. The trailing edge keeps a
  // following write from raising psel in the same step that lowers it.
  task automatic cfg_write(input logic sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == fia_pkg::REG_BASE_INDEX) base_q = val;
    else total_q = val[fia_pkg::TOTAL_W-1:0];
    rebuild_list();
    @(posedge clk);
  endtask

  // Mostly ids that fall inside the table, preferring entries that are in
  // use, with some id zero, some just past the end and some fully random.
  function automatic logic [31:0] pick_flow_id();
    int unsigned t;
    int unsigned idx;
    int          r;
    t = live_entries();
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return $urandom;
    if (r < 24 || t == 0) return base_q + t + $urandom_range(0, 3);
    idx = $urandom_range(0, t - 1);
    for (int k = 0; k < 4 && listed[idx]; k++) idx = $urandom_range(0, t - 1);
    return base_q + idx;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed rows, then phases of random traffic,
  // each under a fresh register setting.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    fia_pkg::fia_in_t it;
    logic [31:0]      new_base;
    logic [10:0]      new_total;
    int               counted;
    int               phase;
    int               n_items;
    int               w_alloc;
    int               r;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    burst_left = 0;

    // After reset: base zero, 1024 entries, entry 1023 first out of the list.
    row_chk(fia_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A,
            32'd1023, '0, fia_pkg::ST_DONE, 11'd1);
    row_chk(fia_pkg::CMD_ALLOC, 32'h0, 64'h0, 32'd1022, '0, fia_pkg::ST_DONE, 11'd2);
    row_chk(fia_pkg::CMD_SET, 32'd1022, '1, '0, '0, fia_pkg::ST_DONE, 11'd2);
    row_chk(fia_pkg::CMD_GET, 32'd1022, 64'h0, '0, '1, fia_pkg::ST_DONE, 11'd2);
    row_chk(fia_pkg::CMD_GET, 32'd0, 64'h0, '0, '0, fia_pkg::ST_IGNORED, 11'd2);
    row_chk(fia_pkg::CMD_SET, 32'd1024, '1, '0, '0, fia_pkg::ST_IGNORED, 11'd2);
    row_chk(fia_pkg::CMD_FREE, 32'd1023, 64'h0, '0, '0, fia_pkg::ST_DONE, 11'd1);
    row_chk(fia_pkg::CMD_FREE, 32'd1022, 64'h0, '0, '0, fia_pkg::ST_DONE, 11'd0);
    // Freeing clears the handle.
    row_chk(fia_pkg::CMD_GET, 32'd1022, 64'h0, '0, '0, fia_pkg::ST_DONE, 11'd0);
    // Double free of the head entry; the count stays at zero.
    row_chk(fia_pkg::CMD_FREE, 32'd1022, 64'h0, '0, '0, fia_pkg::ST_DONE, 11'd0);
    // Free of an entry in the middle of the list moves it to the head.
    row_chk(fia_pkg::CMD_FREE, 32'd5, 64'h0, '0, '0, fia_pkg::ST_DONE, 11'd0);
    row_cmd(fia_pkg::CMD_ALLOC, 32'h0, 64'h0);
    row_cmd(fia_pkg::CMD_ALLOC, 32'h0, 64'h0);
    // Ids that run across the top of the 32-bit space.
    row_cfg(fia_pkg::REG_BASE_INDEX, 32'hFFFF_FFF0);
    row_cfg(fia_pkg::REG_TOTAL_ENTRIES, 32'd32);
    // Entry zero: free is refused, set and get work normally.
    row_chk(fia_pkg::CMD_FREE, 32'hFFFF_FFF0, 64'h0, '0, '0, fia_pkg::ST_IGNORED, 11'd0);
    row_chk(fia_pkg::CMD_SET, 32'hFFFF_FFF0, 64'h0123_4567_89AB_CDEF, '0, '0,
            fia_pkg::ST_DONE, 11'd0);
    row_chk(fia_pkg::CMD_GET, 32'hFFFF_FFF0, 64'h0, '0, 64'h0123_4567_89AB_CDEF,
            fia_pkg::ST_DONE, 11'd0);
    row_chk(fia_pkg::CMD_ALLOC, 32'h0, 64'h0, 32'h0000_000F, '0, fia_pkg::ST_DONE, 11'd1);
    row_chk(fia_pkg::CMD_GET, 32'h0000_0010, 64'h0, '0, '0, fia_pkg::ST_IGNORED, 11'd1);
    // Id zero is refused even though it maps onto a live entry here.
    row_chk(fia_pkg::CMD_FREE, 32'h0, 64'h0, '0, '0, fia_pkg::ST_IGNORED, 11'd1);
    // One live entry whose id wraps to zero; then the list runs dry.
    row_cfg(fia_pkg::REG_BASE_INDEX, 32'hFFFF_FFFF);
    row_cfg(fia_pkg::REG_TOTAL_ENTRIES, 32'd2);
    row_chk(fia_pkg::CMD_ALLOC, 32'h0, 64'h0, 32'h0, '0, fia_pkg::ST_DONE, 11'd1);
    row_chk(fia_pkg::CMD_ALLOC, 32'h0, 64'h0, 32'h0, '0, fia_pkg::ST_NONE_FREE, 11'd1);
    row_chk(fia_pkg::CMD_SET, 32'h0, '1, '0, '0, fia_pkg::ST_IGNORED, 11'd1);
    // A total of zero: nothing free and no valid id at all.
    row_cfg(fia_pkg::REG_TOTAL_ENTRIES, 32'd0);
    row_chk(fia_pkg::CMD_ALLOC, 32'h0, 64'h0, '0, '0, fia_pkg::ST_NONE_FREE, 11'd0);
    row_chk(fia_pkg::CMD_GET, 32'hFFFF_FFFF, 64'h0, '0, '0, fia_pkg::ST_IGNORED, 11'd0);
    // The largest total is clamped to the table depth.
    row_cfg(fia_pkg::REG_TOTAL_ENTRIES, 32'd2047);
    row_chk(fia_pkg::CMD_ALLOC, 32'h0, 64'h0, 32'd1022, '0, fia_pkg::ST_DONE, 11'd1);

    // Reset is synchronous; after its release the block runs its clearing
    // pass, during which in_stall holds back any input transfer.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    base_q  = '0;
    total_q = fia_pkg::TOTAL_RESET;
    rebuild_list();

    for (int k = 0; k < dir_rows.size(); k++) begin
      if (dir_rows[k].is_cfg) begin
        drain_results();
        cfg_write(dir_rows[k].reg_sel, dir_rows[k].cfg_val);
      end else begin
        send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // Random phases. The first few pin down extreme settings; later ones
    // mostly use small tables so that the list empties and refills often.
    // Together with the directed rows they make up about 600 items.
    counted = 0;
    phase   = 0;
    while (counted < 570) begin
      drain_results();
      case (phase)
        0: begin
          new_base  = '0;
          new_total = 11'd1;
        end
        1: begin
          new_base  = $urandom;
          new_total = 11'd1024;
        end
        2: begin
          new_base  = 32'hFFFF_FFFF;
          new_total = 11'd2047;
        end
        3: begin
          new_base  = 32'hFFFF_FFFF - $urandom_range(0, 40);
          new_total = 11'($urandom_range(2, 60));
        end
        default: begin
          r = $urandom_range(0, 3);
          new_base  = (r == 0) ? 32'h0 :
                      (r == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 63) : $urandom;
          new_total = ($urandom_range(0, 4) != 0) ? 11'($urandom_range(1, 48))
                                                  : 11'($urandom_range(0, 2047));
        end
      endcase
      if (phase < 4 || $urandom_range(0, 1) == 1) begin
        cfg_write(fia_pkg::REG_BASE_INDEX, new_base);
      end
      cfg_write(fia_pkg::REG_TOTAL_ENTRIES, {21'd0, new_total});

      // Each phase leans towards allocation or towards freeing so that the
      // count swings between empty and full.
      w_alloc = $urandom_range(20, 70);
      n_items = $urandom_range(30, 80);
      for (int n = 0; n < n_items; n++) begin
        // In two phases the result side holds off for a long stretch while
        // items keep coming, so the block backs up into its input.
        if (n == 5 && (phase == 1 || phase == 4)) hold_req = 1'b1;
        r = $urandom_range(0, 99);
        if (r < w_alloc) it.cmd = fia_pkg::CMD_ALLOC;
        else if (r < w_alloc + (100 - w_alloc) / 2) it.cmd = fia_pkg::CMD_FREE;
        else if ($urandom_range(0, 1) == 0) it.cmd = fia_pkg::CMD_SET;
        else it.cmd = fia_pkg::CMD_GET;
        it.flow_id   = (it.cmd == fia_pkg::CMD_ALLOC && $urandom_range(0, 1) == 0) ?
                       $urandom : pick_flow_id();
        it.obj_value = {$urandom, $urandom};
        send_item(it, 1'b0, '0);
        counted++;
      end
      phase++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side stall. The pattern switches at random between no stall, light
  // and heavy random stall, and a periodic stall whose period shifts it across
  // the phases of the block's work. A long hold-off, when requested, overrides
  // the pattern and is counted down here.
  // ---------------------------------------------------------------------------
  initial begin : result_stall
    int hold_left;
    int mode;
    int mode_left;
    int period;
    int tick;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    period    = 2;
    tick      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = $urandom_range(200, 400);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
        period    = $urandom_range(2, 7);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % period) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking. Every accepted output transfer is compared field by field
  // with the oldest expectation; a transfer with nothing waiting is an error
  // in its own right.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    fia_pkg::fia_out_t want;
    fia_pkg::fia_out_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = out_data;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: id=%h obj=%h status=%0d used=%0d",
                   got.result_id, got.obj_out, got.status, got.used_count);
      end else begin
        want = expected_results.pop_front();
        if (got.result_id !== want.result_id || got.obj_out !== want.obj_out ||
            got.status !== want.status || got.used_count !== want.used_count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected id=%h obj=%h status=%0d used=%0d",
                     want.result_id, want.obj_out, want.status, want.used_count);
            $display("          got      id=%h obj=%h status=%0d used=%0d",
                     got.result_id, got.obj_out, got.status, got.used_count);
          end
        end
      end
    end
  end

  // A hung handshake ends the run well beyond the slowest correct run.
  initial begin : watchdog
    #(64'd10_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
